// File: src/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants for the frequency / amplitude command entry block.
// ----------------------------------------------------------------------------
`default_nettype none

package fac_pkg;

    localparam int MAX_DIGITS_DEF = 3;

    localparam int VAL_W     = 8;
    localparam int ACC_W     = 10;
    localparam int KEY_CNT_W = 2;
    localparam int SER_CNT_W = 3;

    localparam logic [VAL_W-1:0] FREQ_RESET = 8'd1;
    localparam logic [VAL_W-1:0] AMP_RESET  = 8'd255;

    localparam logic [3:0] KEY_STAR = 4'd10;
    localparam logic [3:0] KEY_ZERO = 4'd11;
    localparam logic [3:0] KEY_HASH = 4'd12;
    localparam logic [3:0] KEY_NINE = 4'd9;

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_STAR = 8'h2a;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_F    = 8'h66;

    typedef enum logic [2:0] {
        RSP_NONE        = 3'd0,
        RSP_ACK         = 3'd1,
        RSP_NACK        = 3'd2,
        RSP_INVALID     = 3'd3,
        RSP_FREQ_SET    = 3'd4,
        RSP_AMP_SET     = 3'd5,
        RSP_FREQ_REPORT = 3'd6,
        RSP_AMP_REPORT  = 3'd7
    } rsp_t;

    typedef struct packed {
        logic [VAL_W-1:0]     freq;
        logic [VAL_W-1:0]     amp;
        logic [ACC_W-1:0]     key_acc;
        logic [KEY_CNT_W-1:0] key_cnt;
        logic [ACC_W-1:0]     ser_acc;
        logic [SER_CNT_W-1:0] ser_cnt;
        logic                 freq_arm;
        logic                 amp_arm;
    } st_t;

    typedef struct packed {
        rsp_t             response;
        logic [VAL_W-1:0] value;
    } res_t;

endpackage

`default_nettype wire

// File: src/fac_in_if.sv
// ----------------------------------------------------------------------------
// fac_in_if
// Input channel: keypad key event or received serial byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface fac_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] key_code;
    logic [7:0] rx_byte;

    modport source (output valid, mode, key_code, rx_byte, input ready);
    modport sink   (input valid, mode, key_code, rx_byte, output ready);
endinterface

`default_nettype wire

// File: src/fac_out_if.sv
// ----------------------------------------------------------------------------
// fac_out_if
// Output channel: response code, value and the current settings.
// ----------------------------------------------------------------------------
`default_nettype none

interface fac_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] response;
    logic [7:0] value;
    logic [7:0] freq_now;
    logic [7:0] amp_now;

    modport source (output valid, response, value, freq_now, amp_now, input ready);
    modport sink   (input valid, response, value, freq_now, amp_now, output ready);
endinterface

`default_nettype wire

// File: src/fac_step.sv
// ----------------------------------------------------------------------------
// fac_step
// Decode of one item: next settings, entry state and response.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_step #(
    parameter int MAX_DIGITS = fac_pkg::MAX_DIGITS_DEF
) (
    input  logic          mode,
    input  logic [3:0]    key_code,
    input  logic [7:0]    rx_byte,
    input  fac_pkg::st_t  cur,
    output fac_pkg::st_t  nxt,
    output fac_pkg::res_t res
);

    logic [fac_pkg::ACC_W-1:0] key_digit;
    logic [fac_pkg::ACC_W-1:0] ser_digit;
    logic [fac_pkg::ACC_W-1:0] key_acc10;
    logic [fac_pkg::ACC_W-1:0] ser_acc10;
    logic                      key_over;
    logic                      ser_over;
    logic                      is_digit;
    logic [7:0]                ch_off;

    always_comb
    begin
        if (key_code >= 4'd1 && key_code <= fac_pkg::KEY_NINE)
        begin
            key_digit = fac_pkg::ACC_W'(key_code);
        end
        else
        begin
            key_digit = '0;
        end
        ch_off    = rx_byte - fac_pkg::CH_ZERO;
        ser_digit = fac_pkg::ACC_W'(ch_off[3:0]);
        key_acc10 = {cur.key_acc[fac_pkg::ACC_W-4:0], 3'b000}
                  + {cur.key_acc[fac_pkg::ACC_W-2:0], 1'b0} + key_digit;
        ser_acc10 = {cur.ser_acc[fac_pkg::ACC_W-4:0], 3'b000}
                  + {cur.ser_acc[fac_pkg::ACC_W-2:0], 1'b0} + ser_digit;
        key_over  = |cur.key_acc[fac_pkg::ACC_W-1:fac_pkg::VAL_W];
        ser_over  = |cur.ser_acc[fac_pkg::ACC_W-1:fac_pkg::VAL_W];
        is_digit  = (rx_byte >= fac_pkg::CH_ZERO) && (rx_byte <= fac_pkg::CH_NINE);

        nxt          = cur;
        res.response = fac_pkg::RSP_NONE;
        res.value    = '0;

        if (!mode)
        begin
            if (key_code == fac_pkg::KEY_STAR || key_code == fac_pkg::KEY_HASH)
            begin
                if (key_over)
                begin
                    res.response = fac_pkg::RSP_INVALID;
                end
                else if (key_code == fac_pkg::KEY_STAR)
                begin
                    nxt.freq     = cur.key_acc[fac_pkg::VAL_W-1:0];
                    res.response = fac_pkg::RSP_FREQ_SET;
                    res.value    = cur.key_acc[fac_pkg::VAL_W-1:0];
                end
                else
                begin
                    nxt.amp      = cur.key_acc[fac_pkg::VAL_W-1:0];
                    res.response = fac_pkg::RSP_AMP_SET;
                    res.value    = cur.key_acc[fac_pkg::VAL_W-1:0];
                end
                nxt.key_acc = '0;
                nxt.key_cnt = '0;
            end
            else if (cur.key_cnt < fac_pkg::KEY_CNT_W'(MAX_DIGITS))
            begin
                nxt.key_acc = key_acc10;
                nxt.key_cnt = cur.key_cnt + fac_pkg::KEY_CNT_W'(1);
            end
            else
            begin
                res.response = fac_pkg::RSP_INVALID;
                nxt.key_acc  = '0;
                nxt.key_cnt  = '0;
            end
        end
        else if (cur.freq_arm || cur.amp_arm)
        begin
            if (rx_byte == fac_pkg::CH_BANG)
            begin
                if (cur.ser_cnt > fac_pkg::SER_CNT_W'(MAX_DIGITS) || ser_over)
                begin
                    res.response = fac_pkg::RSP_INVALID;
                end
                else if (cur.amp_arm)
                begin
                    nxt.amp      = cur.ser_acc[fac_pkg::VAL_W-1:0];
                    nxt.amp_arm  = 1'b0;
                    res.response = fac_pkg::RSP_AMP_SET;
                    res.value    = cur.ser_acc[fac_pkg::VAL_W-1:0];
                end
                else
                begin
                    nxt.freq     = cur.ser_acc[fac_pkg::VAL_W-1:0];
                    nxt.freq_arm = 1'b0;
                    res.response = fac_pkg::RSP_FREQ_SET;
                    res.value    = cur.ser_acc[fac_pkg::VAL_W-1:0];
                end
                nxt.ser_acc = '0;
                nxt.ser_cnt = '0;
            end
            else if (!is_digit)
            begin
                res.response = fac_pkg::RSP_INVALID;
                nxt.freq_arm = 1'b0;
                nxt.amp_arm  = 1'b0;
                nxt.ser_acc  = '0;
                nxt.ser_cnt  = '0;
            end
            else if (cur.ser_cnt < fac_pkg::SER_CNT_W'(MAX_DIGITS))
            begin
                nxt.ser_acc = ser_acc10;
                nxt.ser_cnt = cur.ser_cnt + fac_pkg::SER_CNT_W'(1);
            end
            else
            begin
                nxt.ser_cnt = fac_pkg::SER_CNT_W'(MAX_DIGITS + 1);
            end
        end
        else
        begin
            nxt.ser_acc = '0;
            nxt.ser_cnt = '0;
            case (rx_byte)
                fac_pkg::CH_STAR:
                begin
                    nxt.freq_arm = 1'b1;
                    res.response = fac_pkg::RSP_ACK;
                end
                fac_pkg::CH_HASH:
                begin
                    nxt.amp_arm  = 1'b1;
                    res.response = fac_pkg::RSP_ACK;
                end
                fac_pkg::CH_F:
                begin
                    res.response = fac_pkg::RSP_FREQ_REPORT;
                    res.value    = cur.freq;
                end
                fac_pkg::CH_A:
                begin
                    res.response = fac_pkg::RSP_AMP_REPORT;
                    res.value    = cur.amp;
                end
                default:
                begin
                    res.response = fac_pkg::RSP_NACK;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/freq_amp_command_entry.sv
// ----------------------------------------------------------------------------
// freq_amp_command_entry
// Keypad and serial command entry for the frequency and amplitude settings.
// ----------------------------------------------------------------------------
// Each item is a keypad key event or a received serial byte and gives exactly
// one result: a response code, the value set or reported, and both settings
// as they stand after the item. An item is registered at the input, decoded
// combinationally and its result registered at the output, so one item is
// taken every cycle while the output is not stalled; a stalled output holds
// the pipeline. Frequency resets to 1, amplitude to 255.
`default_nettype none

module freq_amp_command_entry #(
    parameter int MAX_DIGITS = fac_pkg::MAX_DIGITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fac_in_if.sink    req,
    fac_out_if.source res
);

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic                      s1_mode_reg;
    logic [3:0]                s1_key_reg;
    logic [7:0]                s1_byte_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    fac_pkg::res_t             out_res_reg;
    logic [fac_pkg::VAL_W-1:0] out_freq_reg;
    logic [fac_pkg::VAL_W-1:0] out_amp_reg;
    fac_pkg::st_t              st_reg;
    fac_pkg::st_t              st_next;
    fac_pkg::st_t              st_step;
    fac_pkg::res_t             step_res;
    logic                      advance;
    logic                      in_take;

    fac_step #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_step (
        .mode     (s1_mode_reg),
        .key_code (s1_key_reg),
        .rx_byte  (s1_byte_reg),
        .cur      (st_reg),
        .nxt      (st_step),
        .res      (step_res)
    );

    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || res.ready);
        req.ready      = !s1_valid_reg || advance;
        in_take        = req.valid && req.ready;
        s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
        st_next        = advance ? st_step : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            st_reg.freq      <= fac_pkg::FREQ_RESET;
            st_reg.amp       <= fac_pkg::AMP_RESET;
            st_reg.key_acc   <= '0;
            st_reg.key_cnt   <= '0;
            st_reg.ser_acc   <= '0;
            st_reg.ser_cnt   <= '0;
            st_reg.freq_arm  <= 1'b0;
            st_reg.amp_arm   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= req.mode;
            s1_key_reg  <= req.key_code;
            s1_byte_reg <= req.rx_byte;
        end
        if (advance)
        begin
            out_res_reg  <= step_res;
            out_freq_reg <= st_step.freq;
            out_amp_reg  <= st_step.amp;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.response = out_res_reg.response;
    assign res.value    = out_res_reg.value;
    assign res.freq_now = out_freq_reg;
    assign res.amp_now  = out_amp_reg;

    a_freq_set_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.response == fac_pkg::RSP_FREQ_SET
        |-> out_freq_reg == out_res_reg.value)
        else $error("freq set result disagrees with freq_now");

    a_amp_set_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.response == fac_pkg::RSP_AMP_SET
        |-> out_amp_reg == out_res_reg.value)
        else $error("amp set result disagrees with amp_now");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.response == fac_pkg::RSP_NONE
        || out_res_reg.response == fac_pkg::RSP_ACK
        || out_res_reg.response == fac_pkg::RSP_NACK
        || out_res_reg.response == fac_pkg::RSP_INVALID)
        |-> out_res_reg.value == '0)
        else $error("value not zero for a response without value");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.key_cnt <= fac_pkg::KEY_CNT_W'(MAX_DIGITS)
        && st_reg.ser_cnt <= fac_pkg::SER_CNT_W'(MAX_DIGITS + 1))
        else $error("digit count beyond limit");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> $stable(st_reg))
        else $error("settings changed while result stalled");

endmodule

`default_nettype wire
